/* sv/tdd_pkg.sv */
package tdd_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DONE   = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_IDLE    = 2'd1,
    SLOT_RUNNING = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BAD     = 2'd2,
    STATUS_RUNNING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_DECIDE
  } fsm_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  level;
    logic [2:0]  slot_index;
    logic [63:0] start_time;
    logic [63:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] added_slot;
    logic       dispatch_valid;
    logic [2:0] dispatch_level;
    logic [2:0] dispatch_slot;
  } rsp_t;

endpackage

/* sv/tdd_table.sv */
module tdd_table import tdd_pkg::*; #(
  parameter int unsigned AW = 6,
  parameter int unsigned TW = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          we_start_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wstate_i,
  input  logic [TW-1:0] wstart_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [1:0]    rstate_o,
  output logic [TW-1:0] rstart_o
);

  localparam int unsigned Depth = 2 ** AW;

  logic [1:0]    state_mem [Depth];
  logic [TW-1:0] start_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      state_mem[waddr_i] <= wstate_i;
    end
    if (re_i) begin
      rstate_o <= state_mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && we_start_i) begin
      start_mem[waddr_i] <= wstart_i;
    end
    if (re_i) begin
      rstart_o <= start_mem[raddr_i];
    end
  end

endmodule

/* sv/timed_task_dispatcher_core.sv */
// Task table of LEVELS x SLOTS_PER_LEVEL slots held in one synchronous memory
// with a single read port. Each request (add, remove, done or tick) is applied
// during one pass over every slot, from the highest level down and slot 0 up,
// while the same pass picks the earliest idle task; one response follows per
// request. After acceptance the scan reads one slot per cycle, then a drain
// state and a decide state register the response; a new request is taken only
// once the previous one has left the decide state. After reset a clearing pass
// empties the table; no request is taken until it ends. A finished response is
// held in an output register, so the next request may be accepted while it
// waits.
module timed_task_dispatcher_core import tdd_pkg::*; #(
  parameter int unsigned LEVELS          = 8,
  parameter int unsigned SLOTS_PER_LEVEL = 8,
  parameter int unsigned TIME_WIDTH      = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned SW = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
  localparam int unsigned AW = LW + SW;
  localparam int unsigned TW = TIME_WIDTH;
  localparam logic [LW-1:0] TopLv  = LW'(LEVELS - 1);
  localparam logic [SW-1:0] LastSl = SW'(SLOTS_PER_LEVEL - 1);

  fsm_e state_q, state_d;

  logic [LW-1:0] lv_cnt_q, lv_cnt_d;
  logic [SW-1:0] sl_cnt_q, sl_cnt_d;
  logic          last_slot;

  // request fields
  op_e           op_q;
  logic          lvl_ok_q, idx_ok_q;
  logic [LW-1:0] tgt_lv_q;
  logic [SW-1:0] tgt_sl_q;
  logic [TW-1:0] start_q, now_q;

  // read pipeline
  logic          rd_vld_q;
  logic [LW-1:0] rd_lv_q;
  logic [SW-1:0] rd_sl_q;
  logic [1:0]    rd_state;
  logic [TW-1:0] rd_start;

  // scan results
  logic              found_q, add_done_q, rm_busy_q;
  logic [SW-1:0]     added_q;
  logic [LW-1:0]     best_lv_q;
  logic [SW-1:0]     best_sl_q;
  logic [TW-1:0]     best_start_q;
  logic [LEVELS-1:0] busy_q;

  // table port
  logic          tbl_we, tbl_we_start, tbl_re;
  logic [AW-1:0] tbl_waddr, tbl_raddr;
  logic [1:0]    tbl_wstate;

  logic in_fire, load_out;

  slot_state_e cur, eff;
  logic [TW-1:0] eff_start;
  logic lv_match, sl_match, data_wr, data_wr_start, add_hit, rm_hit, better;

  logic [TW-1:0] diff;
  logic          due, dispatch;
  status_e       status;
  rsp_t          rsp_d;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign last_slot = (lv_cnt_q == '0) && (sl_cnt_q == LastSl);
  assign load_out  = (state_q == FSM_DECIDE) && (!out_valid_o || !out_stall_i);

  tdd_table #(
    .AW(AW),
    .TW(TW)
  ) u_table (
    .clk_i,
    .we_i      (tbl_we),
    .we_start_i(tbl_we_start),
    .waddr_i   (tbl_waddr),
    .wstate_i  (tbl_wstate),
    .wstart_i  (start_q),
    .re_i      (tbl_re),
    .raddr_i   (tbl_raddr),
    .rstate_o  (rd_state),
    .rstart_o  (rd_start)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    lv_cnt_d = lv_cnt_q;
    sl_cnt_d = sl_cnt_q;
    tbl_re   = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      FSM_CLEAR: begin
        if (last_slot) begin
          state_d  = FSM_IDLE;
          lv_cnt_d = TopLv;
          sl_cnt_d = '0;
        end else if (sl_cnt_q == LastSl) begin
          lv_cnt_d = lv_cnt_q - 1'b1;
          sl_cnt_d = '0;
        end else begin
          sl_cnt_d = sl_cnt_q + 1'b1;
        end
      end
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        tbl_re = 1'b1;
        if (last_slot) begin
          state_d  = FSM_DRAIN;
          lv_cnt_d = TopLv;
          sl_cnt_d = '0;
        end else if (sl_cnt_q == LastSl) begin
          lv_cnt_d = lv_cnt_q - 1'b1;
          sl_cnt_d = '0;
        end else begin
          sl_cnt_d = sl_cnt_q + 1'b1;
        end
      end
      FSM_DRAIN: begin
        state_d = FSM_DECIDE;
      end
      FSM_DECIDE: begin
        if (load_out) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign tbl_raddr = {lv_cnt_q, sl_cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_CLEAR;
      lv_cnt_q <= TopLv;
      sl_cnt_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      lv_cnt_q <= lv_cnt_d;
      sl_cnt_q <= sl_cnt_d;
      rd_vld_q <= (state_q == FSM_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_lv_q <= lv_cnt_q;
    rd_sl_q <= sl_cnt_q;
    if (in_fire) begin
      op_q     <= op_e'(in_req_i.op);
      lvl_ok_q <= (int'(in_req_i.level) < LEVELS);
      idx_ok_q <= (int'(in_req_i.slot_index) < SLOTS_PER_LEVEL);
      tgt_lv_q <= LW'(in_req_i.level);
      tgt_sl_q <= SW'(in_req_i.slot_index);
      start_q  <= in_req_i.start_time[TW-1:0];
      now_q    <= in_req_i.now[TW-1:0];
    end
  end

  // apply the request to the slot just read and rank it
  always_comb begin
    cur           = slot_state_e'(rd_state);
    eff           = cur;
    eff_start     = rd_start;
    data_wr       = 1'b0;
    data_wr_start = 1'b0;
    add_hit       = 1'b0;
    rm_hit        = 1'b0;
    lv_match      = (op_q != OP_TICK) && lvl_ok_q && (rd_lv_q == tgt_lv_q);
    sl_match      = lv_match && idx_ok_q && (rd_sl_q == tgt_sl_q);
    case (op_q)
      OP_ADD: begin
        if (lv_match && !add_done_q && cur == SLOT_EMPTY) begin
          eff           = SLOT_IDLE;
          eff_start     = start_q;
          data_wr       = 1'b1;
          data_wr_start = 1'b1;
          add_hit       = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (sl_match) begin
          if (cur == SLOT_RUNNING) begin
            rm_hit = 1'b1;
          end else begin
            eff     = SLOT_EMPTY;
            data_wr = 1'b1;
          end
        end
      end
      OP_DONE: begin
        if (sl_match && cur == SLOT_RUNNING) begin
          eff     = SLOT_EMPTY;
          data_wr = 1'b1;
        end
      end
      default: begin
      end
    endcase
    better = (eff == SLOT_IDLE) && (!found_q || eff_start < best_start_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      add_done_q <= 1'b0;
      rm_busy_q  <= 1'b0;
      busy_q     <= '0;
    end else if (in_fire) begin
      found_q    <= 1'b0;
      add_done_q <= 1'b0;
      rm_busy_q  <= 1'b0;
      busy_q     <= '0;
    end else if (rd_vld_q) begin
      if (better) begin
        found_q <= 1'b1;
      end
      if (add_hit) begin
        add_done_q <= 1'b1;
      end
      if (rm_hit) begin
        rm_busy_q <= 1'b1;
      end
      if (eff == SLOT_RUNNING) begin
        busy_q[rd_lv_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && better) begin
      best_lv_q    <= rd_lv_q;
      best_sl_q    <= rd_sl_q;
      best_start_q <= eff_start;
    end
    if (rd_vld_q && add_hit) begin
      added_q <= rd_sl_q;
    end
  end

  // dispatch decision
  assign diff     = best_start_q - now_q;
  assign due      = !((best_start_q > now_q) && (diff > TW'(1)));
  assign dispatch = found_q && due && !busy_q[best_lv_q];

  always_comb begin
    status = STATUS_OK;
    if (op_q != OP_TICK) begin
      if (!lvl_ok_q) begin
        status = STATUS_BAD;
      end else if (op_q == OP_ADD) begin
        status = add_done_q ? STATUS_OK : STATUS_FULL;
      end else if (!idx_ok_q) begin
        status = STATUS_BAD;
      end else if (op_q == OP_REMOVE && rm_busy_q) begin
        status = STATUS_RUNNING;
      end
    end
    rsp_d.status         = status;
    rsp_d.added_slot     = add_done_q ? 3'(added_q) : 3'd0;
    rsp_d.dispatch_valid = dispatch;
    rsp_d.dispatch_level = dispatch ? 3'(best_lv_q) : 3'd0;
    rsp_d.dispatch_slot  = dispatch ? 3'(best_sl_q) : 3'd0;
  end

  // table write port
  always_comb begin
    tbl_we       = 1'b0;
    tbl_we_start = 1'b0;
    tbl_waddr    = {rd_lv_q, rd_sl_q};
    tbl_wstate   = eff;
    if (state_q == FSM_CLEAR) begin
      tbl_we     = 1'b1;
      tbl_waddr  = {lv_cnt_q, sl_cnt_q};
      tbl_wstate = SLOT_EMPTY;
    end else if (rd_vld_q) begin
      tbl_we       = data_wr;
      tbl_we_start = data_wr_start;
    end else if (load_out && dispatch) begin
      tbl_we     = 1'b1;
      tbl_waddr  = {best_lv_q, best_sl_q};
      tbl_wstate = SLOT_RUNNING;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rsp_o <= rsp_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_CLEAR |-> in_stall_o)
    else $error("request taken during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == FSM_SCAN)
    else $error("slot data without a scan read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we && tbl_we_start |-> op_q == OP_ADD && rd_vld_q)
    else $error("start time written outside an add");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == FSM_DECIDE)
    else $error("response raised outside decide");

endmodule
